FILE: rtl/core/perlin_noise_2d_fixed_macros.svh
// ----------------------------------------------------------------------------
// Perlin noise assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_2D_FIXED_MACROS_SVH
`define PERLIN_NOISE_2D_FIXED_MACROS_SVH

// same-cycle implication
`define PNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pnf_pkg.sv
// ----------------------------------------------------------------------------
// Perlin noise package
// Types and constants shared by the noise evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pnf_pkg;

  localparam int TableSize  = 256;
  localparam int AddrW      = 8;
  localparam int FracBits   = 16;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  // one word between front and back
  typedef struct packed {
    func_e       func;
    logic [7:0]  load_index;
    logic [7:0]  load_value;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    logic [19:0] fade_x;
    logic [19:0] fade_y;
  } pnf_item_t;

  typedef struct packed {
    logic      valid;
    pnf_item_t item;
  } pnf_push_t;

  // gradient dot product, low four hash bits pick the direction
  function automatic logic signed [18:0] grad_dot(input logic [3:0] h,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
    logic signed [18:0] uu;
    logic signed [18:0] vv;
    logic signed [18:0] su;
    logic signed [18:0] sv;
    uu = (h < 4'd8) ? 19'(dx) : 19'(dy);
    if (h < 4'd4) begin
      vv = 19'(dy);
    end else if (h == 4'd12 || h == 4'd14) begin
      vv = 19'(dx);
    end else begin
      vv = '0;
    end
    su = h[0] ? -uu : uu;
    sv = h[1] ? -vv : vv;
    return su + sv;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pnf_in_if.sv
// ----------------------------------------------------------------------------
// Perlin noise input channel
// Valid/ready channel carrying one load or evaluate word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnf_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [7:0]        load_index;
  logic [7:0]        load_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, func, load_index, load_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, func, load_index, load_value, x_coord, y_coord,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pnf_out_if.sv
// ----------------------------------------------------------------------------
// Perlin noise output channel
// Valid/ready channel carrying one noise result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnf_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pnf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pnf_front.sv
// ----------------------------------------------------------------------------
// Perlin noise front end
// Accepts words, splits coordinates into cell and fraction, computes fades.
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  pnf_in_if.sink                in_i,
  output pnf_pkg::pnf_push_t    push_o,
  input  wire logic             full_i
);

  logic                     en;
  logic [4:1]               valid_q;
  pnf_pkg::pnf_item_t       it1_q, it2_q, it3_q, it4_q;
  pnf_pkg::pnf_item_t       it1_d;
  logic signed [21:0]       sx, sy;
  logic signed [38:0]       p1x_q, p1y_q, p1x_d, p1y_d;
  logic [31:0]              t2x_q, t2y_q;
  logic [19:0]              innx_q, inny_q;
  logic [31:0]              t3x_q, t3y_q;
  logic [35:0]              fpx_q, fpy_q;

  // whole front stalls only when its last word cannot enter the queue
  assign en          = !(valid_q[4] && full_i);
  assign in_i.ready  = en;

  always_comb begin
    it1_d            = '0;
    it1_d.func       = pnf_pkg::func_e'(in_i.func);
    it1_d.load_index = in_i.load_index;
    it1_d.load_value = in_i.load_value;
    it1_d.cell_x     = in_i.x_coord[23:16];
    it1_d.cell_y     = in_i.y_coord[23:16];
    it1_d.frac_x     = in_i.x_coord[15:0];
    it1_d.frac_y     = in_i.y_coord[15:0];
  end

  // fade inner term 6t - 15
  assign sx    = 22'sd6 * $signed({6'b0, it1_q.frac_x}) - 22'sd983040;
  assign sy    = 22'sd6 * $signed({6'b0, it1_q.frac_y}) - 22'sd983040;
  assign p1x_d = $signed({1'b0, it1_q.frac_x}) * sx;
  assign p1y_d = $signed({1'b0, it1_q.frac_y}) * sy;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[3:1], in_i.valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q  <= it1_d;
      it2_q  <= it1_q;
      p1x_q  <= p1x_d;
      p1y_q  <= p1y_d;
      t2x_q  <= it1_q.frac_x * it1_q.frac_x;
      t2y_q  <= it1_q.frac_y * it1_q.frac_y;
      it3_q  <= it2_q;
      innx_q <= 20'(p1x_q >>> pnf_pkg::FracBits) + 20'd655360;
      inny_q <= 20'(p1y_q >>> pnf_pkg::FracBits) + 20'd655360;
      t3x_q  <= t2x_q[31:16] * it2_q.frac_x;
      t3y_q  <= t2y_q[31:16] * it2_q.frac_y;
      it4_q  <= it3_q;
      fpx_q  <= t3x_q[31:16] * innx_q;
      fpy_q  <= t3y_q[31:16] * inny_q;
    end
  end

  always_comb begin
    push_o             = '0;
    push_o.valid       = valid_q[4] && !full_i;
    push_o.item        = it4_q;
    push_o.item.fade_x = fpx_q[35:16];
    push_o.item.fade_y = fpy_q[35:16];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pnf_queue.sv
// ----------------------------------------------------------------------------
// Perlin noise queue
// Short FIFO between the front end and the table/interpolation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pnf_pkg::pnf_push_t push_i,
  output logic               full_o,
  output pnf_pkg::pnf_push_t head_o,
  input  wire logic          pop_i
);

  pnf_pkg::pnf_item_t               mem_q [pnf_pkg::QueueDepth];
  logic [pnf_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [pnf_pkg::QueuePtrW:0]      count_q, count_d;
  logic                             wr, rd;

  assign full_o      = (count_q == (pnf_pkg::QueuePtrW+1)'(pnf_pkg::QueueDepth));
  assign wr          = push_i.valid && !full_o;
  assign rd          = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pnf_back.sv
// ----------------------------------------------------------------------------
// Perlin noise back end
// Hashes through table copies, takes gradients, interpolates, saturates.
// ----------------------------------------------------------------------------
`default_nettype none
`include "perlin_noise_2d_fixed_macros.svh"

module pnf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pnf_pkg::pnf_push_t head_i,
  output logic               pop_o,
  pnf_out_if.source          out_o
);

  logic                  en;
  logic [8:1]            v_q;
  pnf_pkg::pnf_item_t    it1_q, it2_q, it3_q, it4_q;
  logic [7:0]            ta, tb, haa, ha1, hbb, hb1, h00, h01, h10, h11;
  logic [7:0]            a_addr, b_addr;
  logic                  we0, we12, we34;
  logic signed [17:0]    fx, fy, fxm, fym;
  logic signed [18:0]    g00_q, g10_q, g01_q, g11_q;
  logic [19:0]           u5_q, v5_q, v6_q, v7_q;
  pnf_pkg::func_e        f5_q, f6_q, f7_q, f8_q;
  logic signed [19:0]    d0, d1;
  logic signed [40:0]    pm0_q, pm1_q;
  logic signed [18:0]    g00_6_q, g01_6_q;
  logic signed [20:0]    l0_q, l1_q, l0_8_q;
  logic signed [21:0]    dl;
  logic signed [42:0]    pv_q;
  logic signed [22:0]    r;
  logic signed [23:0]    half;
  logic [16:0]           noise_d, noise_q;
  logic                  out_valid_q;

  // the back end moves as one unless a finished word waits on a low out_o.ready
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && head_i.valid;

  assign we0  = en && v_q[1] && (it1_q.func == pnf_pkg::FUNC_LOAD);
  assign we12 = en && v_q[2] && (it2_q.func == pnf_pkg::FUNC_LOAD);
  assign we34 = en && v_q[3] && (it3_q.func == pnf_pkg::FUNC_LOAD);

  // table copy 0: first hash level
  pnf_ram #(.Width(8), .Depth(pnf_pkg::TableSize)) u_ram0 (
    .clk_i, .we_i(we0), .waddr_i(it1_q.load_index), .wdata_i(it1_q.load_value),
    .re_i(en), .raddr_a_i(it1_q.cell_x), .raddr_b_i(it1_q.cell_x + 8'd1),
    .rdata_a_o(ta), .rdata_b_o(tb));

  assign a_addr = ta + it2_q.cell_y;
  assign b_addr = tb + it2_q.cell_y;

  // copies 1 and 2: second level for rows a and b
  pnf_ram #(.Width(8), .Depth(pnf_pkg::TableSize)) u_ram1 (
    .clk_i, .we_i(we12), .waddr_i(it2_q.load_index), .wdata_i(it2_q.load_value),
    .re_i(en), .raddr_a_i(a_addr), .raddr_b_i(a_addr + 8'd1),
    .rdata_a_o(haa), .rdata_b_o(ha1));

  pnf_ram #(.Width(8), .Depth(pnf_pkg::TableSize)) u_ram2 (
    .clk_i, .we_i(we12), .waddr_i(it2_q.load_index), .wdata_i(it2_q.load_value),
    .re_i(en), .raddr_a_i(b_addr), .raddr_b_i(b_addr + 8'd1),
    .rdata_a_o(hbb), .rdata_b_o(hb1));

  // copies 3 and 4: corner hashes
  pnf_ram #(.Width(8), .Depth(pnf_pkg::TableSize)) u_ram3 (
    .clk_i, .we_i(we34), .waddr_i(it3_q.load_index), .wdata_i(it3_q.load_value),
    .re_i(en), .raddr_a_i(haa), .raddr_b_i(ha1),
    .rdata_a_o(h00), .rdata_b_o(h01));

  pnf_ram #(.Width(8), .Depth(pnf_pkg::TableSize)) u_ram4 (
    .clk_i, .we_i(we34), .waddr_i(it3_q.load_index), .wdata_i(it3_q.load_value),
    .re_i(en), .raddr_a_i(hbb), .raddr_b_i(hb1),
    .rdata_a_o(h10), .rdata_b_o(h11));

  // corner offsets
  assign fx  = $signed({2'b0, it4_q.frac_x});
  assign fy  = $signed({2'b0, it4_q.frac_y});
  assign fxm = fx - 18'sd65536;
  assign fym = fy - 18'sd65536;

  assign d0 = 20'(g10_q) - 20'(g00_q);
  assign d1 = 20'(g11_q) - 20'(g01_q);
  assign dl = 22'(l1_q) - 22'(l0_q);

  // final lerp, (r+1)/2 and clamp
  always_comb begin
    r    = 23'(l0_8_q) + 23'(pv_q >>> pnf_pkg::FracBits);
    half = (24'(r) + 24'sd65536) >>> 1;
    if (half < 24'sd0) begin
      noise_d = '0;
    end else if (half > 24'sd65536) begin
      noise_d = 17'd65536;
    end else begin
      noise_d = half[16:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[7:1], head_i.valid};
      out_valid_q <= v_q[8] && (f8_q == pnf_pkg::FUNC_EVAL);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q   <= head_i.item;
      it2_q   <= it1_q;
      it3_q   <= it2_q;
      it4_q   <= it3_q;
      g00_q   <= pnf_pkg::grad_dot(h00[3:0], fx, fy);
      g10_q   <= pnf_pkg::grad_dot(h10[3:0], fxm, fy);
      g01_q   <= pnf_pkg::grad_dot(h01[3:0], fx, fym);
      g11_q   <= pnf_pkg::grad_dot(h11[3:0], fxm, fym);
      u5_q    <= it4_q.fade_x;
      v5_q    <= it4_q.fade_y;
      f5_q    <= it4_q.func;
      pm0_q   <= $signed({1'b0, u5_q}) * d0;
      pm1_q   <= $signed({1'b0, u5_q}) * d1;
      g00_6_q <= g00_q;
      g01_6_q <= g01_q;
      v6_q    <= v5_q;
      f6_q    <= f5_q;
      l0_q    <= 21'(g00_6_q) + 21'(pm0_q >>> pnf_pkg::FracBits);
      l1_q    <= 21'(g01_6_q) + 21'(pm1_q >>> pnf_pkg::FracBits);
      v7_q    <= v6_q;
      f7_q    <= f6_q;
      pv_q    <= $signed({1'b0, v7_q}) * dl;
      l0_8_q  <= l0_q;
      f8_q    <= f7_q;
      noise_q <= noise_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = noise_q;

  `PNF_ASSERT_NEXT(a_load_no_word, en && v_q[8] && f8_q == pnf_pkg::FUNC_LOAD, !out_valid_q, "load item produced a result")
  `PNF_ASSERT_NOW(a_noise_range, out_valid_q, noise_q <= 17'd65536, "noise above saturation")
  `PNF_ASSERT_NEXT(a_stall_freeze, !en, $stable(v_q), "pipeline moved while stalled")
  `PNF_ASSERT_NOW(a_no_write_stalled, !en, !we0 && !we12 && !we34, "table written while stalled")

endmodule

`default_nettype wire

FILE: rtl/core/perlin_noise_2d_fixed.sv
// ----------------------------------------------------------------------------
// 2D improved Perlin noise, fixed point
// Pipelined evaluator with a front end, a short queue and a table back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per valid/ready handshake. func = 0 writes
//   load_value into permutation entry load_index and returns nothing.
//   func = 1 evaluates noise at signed Q16.16 (x_coord, y_coord) and
//   returns one word on out_o: noise_value, (r+1)/2 in unsigned Q1.16,
//   saturated to 0..65536. Results come back in input order.
//   It takes one word per cycle while no result waits on out_o, carried
//   by the fully pipelined fade multipliers and the five table copies
//   across the three hash levels. From acceptance to out_o.valid a word
//   passes 4 front stages, the queue, 8 back stages and the output register.
//   A load reaches each table copy in order with the evaluations, so every
//   evaluation sees exactly the loads accepted before it.
//   When out_o.ready is low while a result waits, the back end freezes; the
//   4-word queue absorbs the front end, after which in_i.ready drops.
//   Reset clears control state only; table entries must be loaded before
//   they are used.
// ----------------------------------------------------------------------------
`default_nettype none

module perlin_noise_2d_fixed (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pnf_in_if.sink    in_i,
  pnf_out_if.source out_o
);

  pnf_pkg::pnf_push_t push, head;
  logic               full, pop;

  pnf_front u_front (
    .clk_i, .rst_ni, .in_i, .push_o(push), .full_i(full));

  pnf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .head_o(head), .pop_i(pop));

  pnf_back u_back (
    .clk_i, .rst_ni, .head_i(head), .pop_o(pop), .out_o);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Perlin noise evaluator testbench
// Fills the permutation table, runs a table of directed words, then random
// load and evaluate words with random source gaps and sink stalls. Each
// evaluate is predicted in fixed point or typed by hand, checked in order on out_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int RandWords  = 1430;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;

  // one directed row; has_exp marks a result typed in by hand
  typedef struct {
    pnf_pkg::func_e func;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] xc;
    logic [31:0] yc;
    bit          has_exp;
    logic [16:0] exp_noise;
  } noise_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pnf_in_if  in_ch ();
  pnf_out_if out_ch ();

  perlin_noise_2d_fixed u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk = ~clk;

  // predictor state and expected noise words
  logic [7:0]  perm_copy [pnf_pkg::TableSize];
  logic [16:0] noise_q [$];
  int          n_fail = 0;
  int          n_loads = 0;
  int          n_evals = 0;
  int          n_checked = 0;
  int          cycles = 0;
  bit          stim_done = 1'b0;

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> pnf_pkg::FracBits;
  endfunction

  function automatic longint fade(longint t);
    longint one;
    longint inner;
    longint t3;
    one   = longint'(1) << pnf_pkg::FracBits;
    inner = fx_mul(t, 6 * t - 15 * one) + 10 * one;
    t3    = fx_mul(fx_mul(t, t), t);
    return fx_mul(t3, inner);
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint dx, longint dy);
    logic [3:0] h;
    longint gu;
    longint gv;
    h  = hash[3:0];
    gu = (h < 8) ? dx : dy;
    gv = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  function automatic logic [7:0] lookup(int unsigned idx);
    return perm_copy[idx % pnf_pkg::TableSize];
  endfunction

  function automatic logic [16:0] noise_at(logic [31:0] xc, logic [31:0] yc);
    longint one;
    int unsigned cx;
    int unsigned cy;
    int unsigned ha;
    int unsigned hb;
    longint fx;
    longint fy;
    longint u;
    longint v;
    longint r;
    longint res;
    one = longint'(1) << pnf_pkg::FracBits;
    cx  = (int'(xc) >>> pnf_pkg::FracBits) & (pnf_pkg::TableSize - 1);
    cy  = (int'(yc) >>> pnf_pkg::FracBits) & (pnf_pkg::TableSize - 1);
    fx  = longint'(xc[15:0]);
    fy  = longint'(yc[15:0]);
    u   = fade(fx);
    v   = fade(fy);
    ha  = lookup(cx) + cy;
    hb  = lookup(cx + 1) + cy;
    r = lerp(lerp(corner_dot(lookup(lookup(ha)), fx, fy),
                  corner_dot(lookup(lookup(hb)), fx - one, fy), u),
             lerp(corner_dot(lookup(lookup(ha + 1)), fx, fy - one),
                  corner_dot(lookup(lookup(hb + 1)), fx - one, fy - one), u), v);
    res = ((r + one) * 32768) >>> pnf_pkg::FracBits;
    if (res < 0) res = 0;
    if (res > 65536) res = 65536;
    return res[16:0];
  endfunction

  // present one word at the falling edge and wait for its handshake
  task automatic send_word(noise_row_t row);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func       = row.func;
    in_ch.load_index = row.idx;
    in_ch.load_value = row.val;
    in_ch.x_coord    = row.xc;
    in_ch.y_coord    = row.yc;
    in_ch.valid      = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    if (row.func == pnf_pkg::FUNC_LOAD) begin
      perm_copy[row.idx] = row.val;
      n_loads++;
    end else begin
      noise_q.push_back(row.has_exp ? row.exp_noise : noise_at(row.xc, row.yc));
      n_evals++;
    end
    @(negedge clk);
  endtask

  function automatic noise_row_t eval_row(logic [31:0] xc, logic [31:0] yc);
    noise_row_t r;
    r = '{pnf_pkg::FUNC_EVAL, 8'h00, 8'h00, xc, yc, 1'b0, 17'd0};
    return r;
  endfunction

  // sink stalls: ready low for a drawn number of cycles per word
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 5);
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [16:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (noise_q.size() == 0) begin
        $error("noise_value: unexpected word, actual %0d", out_ch.noise_value);
        n_fail++;
      end else begin
        want = noise_q.pop_front();
        n_checked++;
        if (out_ch.noise_value !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, out_ch.noise_value);
          n_fail++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    noise_row_t rows [$];
    noise_row_t r;
    int k;
    in_ch.valid      = 1'b0;
    in_ch.func       = pnf_pkg::FUNC_LOAD;
    in_ch.load_index = '0;
    in_ch.load_value = '0;
    in_ch.x_coord    = '0;
    in_ch.y_coord    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole table with a permutation before any read
    for (k = 0; k < pnf_pkg::TableSize; k++) begin
      r = '{pnf_pkg::FUNC_LOAD, 8'(k), 8'((k * 167 + 13) % 256), '0, '0, 1'b0, 17'd0};
      send_word(r);
    end

    // directed: lattice points give exactly one half, plus field extremes
    rows.push_back('{pnf_pkg::FUNC_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000,
                     1'b1, 17'd32768});
    rows.push_back('{pnf_pkg::FUNC_EVAL, 8'h00, 8'h00, 32'h0005_0000, 32'hFFFD_0000,
                     1'b1, 17'd32768});
    rows.push_back('{pnf_pkg::FUNC_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_0000,
                     1'b1, 17'd32768});
    rows.push_back(eval_row(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    rows.push_back(eval_row(32'h8000_0000, 32'h8000_0000));
    rows.push_back(eval_row(32'h7FFF_FFFF, 32'h8000_0000));
    rows.push_back(eval_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    rows.push_back(eval_row(32'h0000_FFFF, 32'h0000_0001));
    rows.push_back(eval_row(32'h0000_8000, 32'h0000_8000));
    rows.push_back(eval_row(32'h00FF_8000, 32'h00FF_4000)); // cell 255, cell + 1 wraps to 0
    rows.push_back(eval_row(32'hFFFF_4000, 32'h0100_C000));
    // table extremes, then reads through them (hash overflow paths)
    rows.push_back('{pnf_pkg::FUNC_LOAD, 8'hFF, 8'hFF, '0, '0, 1'b0, 17'd0});
    rows.push_back('{pnf_pkg::FUNC_LOAD, 8'h00, 8'h00, '0, '0, 1'b0, 17'd0});
    rows.push_back(eval_row(32'h00FF_3000, 32'h00FF_D000));
    rows.push_back(eval_row(32'h0000_2000, 32'h00FF_E000));
    rows.push_back(eval_row(32'hFFFF_0001, 32'h0000_FFFE));
    foreach (rows[i]) send_word(rows[i]);

    // random words: mostly evaluations, some table rewrites
    for (k = 0; k < RandWords; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = '{pnf_pkg::FUNC_LOAD, 8'($urandom), 8'($urandom), '0, '0, 1'b0, 17'd0};
      end else if ($urandom_range(0, 1) == 0) begin
        r = eval_row($urandom, $urandom);
      end else begin
        r = eval_row({16'($urandom_range(0, 8) - 4), 16'($urandom)},
                     {16'($urandom_range(0, 8) - 4), 16'($urandom)});
      end
      send_word(r);
    end
    in_ch.valid = 1'b0;
    stim_done = 1'b1;

    wait (noise_q.size() == 0);
    repeat (DrainWait) @(posedge clk);
    $display("covered %0d table loads and %0d noise evaluations, %0d words checked",
             n_loads, n_evals, n_checked);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("FAIL");
    end
    $finish;
  end

endmodule
